// File: rtl/isotp_pkg.sv
`default_nettype none

package isotp_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FLOW    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_IDLE_TIMEOUT = 3'd0,
    ERR_BAD_TYPE     = 3'd1,
    ERR_SF_LENGTH    = 3'd2,
    ERR_FF_ZERO      = 3'd3,
    ERR_CF_TIMEOUT   = 3'd4,
    ERR_NOT_CF       = 3'd5,
    ERR_SEQUENCE     = 3'd6
  } err_t;

  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  localparam logic [7:0] FC_CTS = 8'h30;

  localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] CFG_SEP_TIME   = 2'd1;
  localparam logic [1:0] CFG_PAD        = 2'd2;

  typedef struct packed {
    logic [7:0] blk_size;
    logic [7:0] sep_time;
    logic [7:0] pad;
  } cfg_t;

  typedef struct packed {
    logic            is_error;
    err_t            code;
    logic            has_flow;
    logic            end_mark;
    logic [2:0]      cnt;
    logic [7:0][7:0] data;
  } cmd_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/isotp_front.sv
`default_nettype none

module isotp_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     func,
  input  wire logic [7:0][7:0]          frame,
  input  wire isotp_pkg::q_stat_t       q_stat,
  output logic                          push,
  output isotp_pkg::cmd_t               cmd
);
  import isotp_pkg::*;

  logic        receiving;
  logic        receiving_next;
  logic [11:0] remaining;
  logic [11:0] remaining_next;
  logic [3:0]  exp_seq;
  logic [3:0]  exp_seq_next;

  logic [3:0]  pci_type;
  logic [3:0]  pci_low;
  logic [11:0] ff_len;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;
  assign pci_type = frame[0][7:4];
  assign pci_low  = frame[0][3:0];
  assign ff_len   = {pci_low, frame[1]};

  always_comb begin
    receiving_next = receiving;
    remaining_next = remaining;
    exp_seq_next   = exp_seq;
    cmd            = '0;
    cmd.code       = ERR_IDLE_TIMEOUT;
    for (int i = 0; i < 7; i++) begin
      cmd.data[i] = frame[i + 1];
    end
    cmd.data[7] = 8'h00;

    if (!receiving) begin
      if (func) begin
        cmd.is_error = 1'b1;
        cmd.code     = ERR_IDLE_TIMEOUT;
      end else begin
        case (pci_type)
          PCI_SF: begin
            if (pci_low == 4'd0 || pci_low > 4'd7) begin
              cmd.is_error = 1'b1;
              cmd.code     = ERR_SF_LENGTH;
            end else begin
              cmd.cnt      = pci_low[2:0];
              cmd.end_mark = 1'b1;
            end
          end
          PCI_FF: begin
            if (ff_len == 12'd0) begin
              cmd.is_error = 1'b1;
              cmd.code     = ERR_FF_ZERO;
            end else begin
              for (int i = 0; i < 6; i++) begin
                cmd.data[i] = frame[i + 2];
              end
              cmd.data[6]  = 8'h00;
              cmd.cnt      = (ff_len < 12'd6) ? ff_len[2:0] : 3'd6;
              cmd.end_mark = (ff_len <= 12'd6);
              cmd.has_flow = 1'b1;
              if (ff_len > 12'd6) begin
                receiving_next = 1'b1;
                remaining_next = ff_len - 12'd6;
                exp_seq_next   = 4'd1;
              end
            end
          end
          default: begin
            cmd.is_error = 1'b1;
            cmd.code     = ERR_BAD_TYPE;
          end
        endcase
      end
    end else begin
      if (func) begin
        cmd.is_error = 1'b1;
        cmd.code     = ERR_CF_TIMEOUT;
      end else if (pci_type != PCI_CF) begin
        cmd.is_error = 1'b1;
        cmd.code     = ERR_NOT_CF;
      end else if (pci_low != exp_seq) begin
        cmd.is_error = 1'b1;
        cmd.code     = ERR_SEQUENCE;
      end else begin
        cmd.cnt        = (remaining < 12'd7) ? remaining[2:0] : 3'd7;
        cmd.end_mark   = (remaining <= 12'd7);
        remaining_next = remaining - {9'd0, cmd.cnt};
        exp_seq_next   = exp_seq + 4'd1;
        if (remaining <= 12'd7) begin
          receiving_next = 1'b0;
          remaining_next = 12'd0;
          exp_seq_next   = 4'd1;
        end
      end
    end

    if (cmd.is_error) begin
      receiving_next = 1'b0;
      remaining_next = 12'd0;
      exp_seq_next   = 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving <= 1'b0;
      remaining <= 12'd0;
      exp_seq   <= 4'd1;
    end else if (push) begin
      receiving <= receiving_next;
      remaining <= remaining_next;
      exp_seq   <= exp_seq_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/isotp_queue.sv
`default_nettype none

module isotp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire isotp_pkg::cmd_t    push_cmd,
  input  wire logic               pop,
  output isotp_pkg::cmd_t         head,
  output isotp_pkg::q_stat_t      q_stat
);
  import isotp_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign q_stat.full       = (count == 2'd2);
  assign q_stat.head_valid = (count != 2'd0);
  assign head              = slots[rd_ptr];
  assign do_push           = push && !q_stat.full;
  assign do_pop            = pop && q_stat.head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/isotp_back.sv
`default_nettype none

module isotp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire isotp_pkg::cmd_t    head,
  input  wire isotp_pkg::q_stat_t q_stat,
  input  wire isotp_pkg::cfg_t    cfg,
  output logic                    pop,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output isotp_pkg::kind_t        kind,
  output logic [7:0]              value,
  output isotp_pkg::err_t         error_code,
  output logic                    message_end,
  output logic                    run_last
);
  import isotp_pkg::*;

  logic [3:0] idx;
  logic       step;
  logic       last;
  logic [3:0] flow_pos;
  kind_t      r_kind;
  logic [7:0] r_value;
  err_t       r_code;
  logic       r_end;

  assign step     = q_stat.head_valid && (!out_valid || out_ready);
  assign pop      = step && last;
  assign flow_pos = idx - {1'b0, head.cnt};

  always_comb begin
    r_kind  = KIND_PAYLOAD;
    r_value = 8'h00;
    r_code  = ERR_IDLE_TIMEOUT;
    r_end   = 1'b0;
    last    = 1'b0;
    if (head.is_error) begin
      r_kind = KIND_ERROR;
      r_code = head.code;
      last   = 1'b1;
    end else if (idx < {1'b0, head.cnt}) begin
      r_value = head.data[idx[2:0]];
      r_end   = head.end_mark && (idx == {1'b0, head.cnt} - 4'd1);
      last    = !head.has_flow && (idx == {1'b0, head.cnt} - 4'd1);
    end else begin
      r_kind = KIND_FLOW;
      case (flow_pos[2:0])
        3'd0:    r_value = FC_CTS;
        3'd1:    r_value = cfg.blk_size;
        3'd2:    r_value = cfg.sep_time;
        default: r_value = cfg.pad;
      endcase
      last = (flow_pos[2:0] == 3'd7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        idx       <= last ? 4'd0 : idx + 4'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      kind        <= r_kind;
      value       <= r_value;
      error_code  <= r_code;
      message_end <= r_end;
      run_last    <= last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/isotp_reassembly_receiver_core.sv
`default_nettype none

// channel  | dir | signals                          | contents
// s        | in  | s_tvalid s_tready s_tdata s_tuser | CAN frame or receive timeout
// m        | out | m_tvalid m_tready m_tdata m_tuser | payload, flow-control, error
//          |     | m_tlast                          | last result of one item
// cfg      | in  | cfg_write cfg_index cfg_data     | flow-control settings
//
// Each item yields 1 to 14 results, one per cycle from the output register;
// the result serializer sets the rate. A two-entry command queue lets the
// front accept new items while earlier results still drain.
// Reset clears protocol state, queue, output valid and the settings to zero.
// Stalls on m hold the output; s stalls only when the queue is full.

module isotp_reassembly_receiver_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // byte_0 .. byte_7
  input  wire logic [0:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // value[7:0], error_code[10:8], zero
  output logic [2:0]       m_tuser,   // kind[1:0], message_end[2]
  output logic             m_tlast,   // run_last
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import isotp_pkg::*;

  cfg_t            cfg;
  cmd_t            push_cmd;
  cmd_t            head;
  q_stat_t         q_stat;
  logic            push;
  logic            pop;
  logic [7:0][7:0] frame;
  kind_t           kind;
  logic [7:0]      value;
  err_t            error_code;
  logic            message_end;

  assign frame = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BLOCK_SIZE: cfg.blk_size <= cfg_data;
        CFG_SEP_TIME:   cfg.sep_time <= cfg_data;
        CFG_PAD:        cfg.pad      <= cfg_data;
        default:        cfg          <= cfg;
      endcase
    end
  end

  isotp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .func     (s_tuser[0]),
    .frame    (frame),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  isotp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  isotp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .cfg         (cfg),
    .pop         (pop),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .kind        (kind),
    .value       (value),
    .error_code  (error_code),
    .message_end (message_end),
    .run_last    (m_tlast)
  );

  assign m_tdata = {5'd0, error_code, value};
  assign m_tuser = {message_end, kind};

`ifndef SYNTH
  a_error_single : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && kind == KIND_ERROR) |-> m_tlast)
    else $error("error result not marked last");

  a_end_payload : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && message_end) |-> (kind == KIND_PAYLOAD))
    else $error("message end on non-payload result");

  a_stall_busy : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_stat.head_valid)
    else $error("input stalled with empty queue");
`endif

endmodule

`default_nettype wire

// File: sim/isotp_reassembly_receiver_core_test.sv
`timescale 1ns / 1ps

module isotp_reassembly_receiver_core_test;
  import isotp_pkg::*;

  localparam err_t NO_ERROR = ERR_IDLE_TIMEOUT;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  class reassembly_tracker;
    typedef struct {
      kind_t      kind;
      logic [7:0] value;
      err_t       code;
      logic       msg_end;
      logic       last;
    } rx_result_t;

    rx_result_t expected_results[$];
    int failures;
    logic [7:0] blk_size, sep_time, pad;
    logic receiving;
    logic [11:0] msg_len, got;
    logic [3:0] next_seq;

    function new();
      failures = 0;
      blk_size = '0;
      sep_time = '0;
      pad = '0;
      restart();
    endfunction

    function void restart();
      receiving = 1'b0;
      msg_len = '0;
      got = '0;
      next_seq = 4'd1;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_register(logic [1:0] index, logic [7:0] data);
      case (index)
        CFG_BLOCK_SIZE: blk_size = data;
        CFG_SEP_TIME: sep_time = data;
        CFG_PAD: pad = data;
        default: ;
      endcase
    endfunction

    function void add(kind_t kind, logic [7:0] value, err_t code, logic msg_end);
      rx_result_t r;
      r.kind = kind;
      r.value = value;
      r.code = code;
      r.msg_end = msg_end;
      r.last = 1'b0;
      expected_results = {expected_results, r};
    endfunction

    function void fail(err_t code);
      restart();
      add(KIND_ERROR, 8'h00, code, 1'b0);
    endfunction

    function void take_frame(logic func, logic [63:0] data);
      logic [7:0] b [8];
      logic [3:0] pci, low;
      logic [11:0] len, remaining;
      int cnt;
      rx_result_t r;
      for (int i = 0; i < 8; i++) b[i] = data[8*i +: 8];
      pci = b[0][7:4];
      low = b[0][3:0];
      if (!receiving) begin
        if (func) begin
          fail(ERR_IDLE_TIMEOUT);
        end else if (pci == PCI_SF) begin
          if (low == 0 || low > 7) begin
            fail(ERR_SF_LENGTH);
          end else begin
            for (int i = 0; i < low; i++)
              add(KIND_PAYLOAD, b[1+i], NO_ERROR, i + 1 == low);
          end
        end else if (pci == PCI_FF) begin
          len = {low, b[1]};
          if (len == 0) begin
            fail(ERR_FF_ZERO);
          end else begin
            cnt = len < 6 ? len : 6;
            for (int i = 0; i < cnt; i++)
              add(KIND_PAYLOAD, b[2+i], NO_ERROR, len <= 6 && i + 1 == cnt);
            add(KIND_FLOW, FC_CTS, NO_ERROR, 1'b0);
            add(KIND_FLOW, blk_size, NO_ERROR, 1'b0);
            add(KIND_FLOW, sep_time, NO_ERROR, 1'b0);
            repeat (5) add(KIND_FLOW, pad, NO_ERROR, 1'b0);
            if (len > 6) begin
              receiving = 1'b1;
              msg_len = len;
              got = 12'(cnt);
              next_seq = 4'd1;
            end
          end
        end else begin
          fail(ERR_BAD_TYPE);
        end
      end else begin
        if (func) begin
          fail(ERR_CF_TIMEOUT);
        end else if (pci != PCI_CF) begin
          fail(ERR_NOT_CF);
        end else if (low != next_seq) begin
          fail(ERR_SEQUENCE);
        end else begin
          remaining = msg_len - got;
          cnt = remaining < 7 ? remaining : 7;
          for (int i = 0; i < cnt; i++)
            add(KIND_PAYLOAD, b[1+i], NO_ERROR, remaining <= 7 && i + 1 == cnt);
          got = got + 12'(cnt);
          next_seq = next_seq + 4'd1;
          if (remaining <= 7) restart();
        end
      end
      r = expected_results[expected_results.size() - 1];
      r.last = 1'b1;
      expected_results[expected_results.size() - 1] = r;
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
      end
    endfunction

    function void check_result(logic [15:0] tdata, logic [2:0] tuser, logic tlast);
      rx_result_t r;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %h",
                 $time, tdata, tuser);
        return;
      end
      r = expected_results.pop_front();
      compare_field("kind", {6'b0, r.kind}, {6'b0, tuser[1:0]});
      compare_field("value", r.value, tdata[7:0]);
      compare_field("error_code", {5'b0, r.code}, {5'b0, tdata[10:8]});
      compare_field("message_end", {7'b0, r.msg_end}, {7'b0, tuser[2]});
      compare_field("run_last", {7'b0, r.last}, {7'b0, tlast});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid;
  logic s_tready;
  logic [63:0] s_tdata;
  logic [0:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [15:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  reassembly_tracker tracker = new();
  int frames_sent = 0;

  isotp_reassembly_receiver_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser, m_tlast);
  end

  function automatic logic [63:0] sf_frame(int len);
    logic [63:0] f;
    f = {$urandom, $urandom};
    f[7:0] = {PCI_SF, 4'(len)};
    return f;
  endfunction

  function automatic logic [63:0] ff_frame(int len);
    logic [63:0] f;
    logic [11:0] l;
    l = 12'(len);
    f = {$urandom, $urandom};
    f[15:0] = {l[7:0], PCI_FF, l[11:8]};
    return f;
  endfunction

  function automatic logic [63:0] cf_frame(logic [3:0] seq);
    logic [63:0] f;
    f = {$urandom, $urandom};
    f[7:0] = {PCI_CF, seq};
    return f;
  endfunction

  task automatic offer_frame(input logic func, input logic [63:0] data);
    int gap;
    gap = (frames_sent % 40 < 10) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = func;
    s_tdata = data;
    do @(posedge clk); while (!s_tready);
    tracker.take_frame(func, data);
    frames_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len, input bit allow_break);
    logic [3:0] seq;
    int left;
    offer_frame(1'b0, ff_frame(len));
    if (len <= 6) return;
    left = len - 6;
    seq = 1;
    while (left > 0) begin
      if (allow_break && $urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0: offer_frame(1'b1, {$urandom, $urandom});
          1: offer_frame(1'b0, cf_frame(seq + 4'($urandom_range(1, 15))));
          2: offer_frame(1'b0, sf_frame($urandom_range(1, 7)));
          default: offer_frame(1'b0, {$urandom, $urandom});
        endcase
        return;
      end
      offer_frame(1'b0, cf_frame(seq));
      seq++;
      left -= 7;
    end
  endtask

  task automatic random_traffic(input int count);
    int target, roll;
    target = frames_sent + count;
    while (frames_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        send_message(roll < 6 ? $urandom_range(41, 160) : $urandom_range(7, 40), 1'b1);
      end else if (roll < 65) begin
        offer_frame(1'b0, sf_frame($urandom_range(1, 7)));
      end else if (roll < 75) begin
        offer_frame(1'b0, ff_frame($urandom_range(1, 6)));
      end else if (roll < 82) begin
        offer_frame(1'b0, ff_frame($urandom_range(0, 4095)));
      end else begin
        offer_frame($urandom_range(0, 3) == 0, {$urandom, $urandom});
      end
    end
  endtask

  task automatic configure(input logic [7:0] bs, input logic [7:0] st, input logic [7:0] pd);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    idx = '{CFG_BLOCK_SIZE, CFG_SEP_TIME, CFG_PAD, CFG_UNUSED};
    val = '{bs, st, pd, 8'($urandom_range(0, 255))};
    for (int i = 0; i < 4; i++) begin
      cfg_write = 1'b1;
      cfg_index = idx[i];
      cfg_data = val[i];
      tracker.write_register(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_write = 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int stall, taken;
    taken = 0;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = (taken % 64 < 16) ? 0 : $urandom_range(0, 6);
      if (taken == 300 || taken == 900) stall = 250;
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    configure(8'hFF, 8'h00, 8'hAA);

    offer_frame(1'b1, '1);
    offer_frame(1'b0, '0);
    offer_frame(1'b0, sf_frame(8));
    offer_frame(1'b0, sf_frame(15));
    offer_frame(1'b0, sf_frame(1));
    offer_frame(1'b0, {56'hFF_FFFF_FFFF_FFFF, PCI_SF, 4'd7});
    offer_frame(1'b0, cf_frame(1));
    offer_frame(1'b0, {$urandom, 24'($urandom), 8'hF5});
    offer_frame(1'b0, {56'h0, FC_CTS});
    offer_frame(1'b0, ff_frame(0));
    offer_frame(1'b0, ff_frame(1));
    offer_frame(1'b0, ff_frame(6));
    send_message(7, 1'b0);
    send_message(13, 1'b0);
    offer_frame(1'b0, ff_frame(4095));
    offer_frame(1'b0, cf_frame(1));
    offer_frame(1'b0, cf_frame(2));
    offer_frame(1'b1, '0);
    offer_frame(1'b0, ff_frame(20));
    offer_frame(1'b0, cf_frame(2));
    offer_frame(1'b0, ff_frame(100));
    offer_frame(1'b0, sf_frame(3));
    offer_frame(1'b0, ff_frame(50));
    offer_frame(1'b0, ff_frame(8));

    settle();
    configure(8'h00, 8'hFF, 8'h00);
    random_traffic(90);
    settle();
    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    random_traffic(90);
    settle();
    configure(8'hFF, 8'hFF, 8'hFF);
    random_traffic(75);
    settle();
    repeat (20) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
